[hdl/crfu_pkg.sv]
// Package: types, instruction codes and constants of the register and flag unit.
`timescale 1ns / 1ps
`default_nettype none
package crfu_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [5:0] OP_NOP = 6'd0;
	localparam logic [5:0] OP_XBA = 6'd1;
	localparam logic [5:0] OP_XCE = 6'd2;
	localparam logic [5:0] OP_CLC = 6'd3;
	localparam logic [5:0] OP_CLD = 6'd4;
	localparam logic [5:0] OP_CLI = 6'd5;
	localparam logic [5:0] OP_CLV = 6'd6;
	localparam logic [5:0] OP_SEC = 6'd7;
	localparam logic [5:0] OP_SED = 6'd8;
	localparam logic [5:0] OP_SEI = 6'd9;
	localparam logic [5:0] OP_REP = 6'd10;
	localparam logic [5:0] OP_SEP = 6'd11;
	localparam logic [5:0] OP_TAX = 6'd12;
	localparam logic [5:0] OP_TAY = 6'd13;
	localparam logic [5:0] OP_TXA = 6'd14;
	localparam logic [5:0] OP_TXY = 6'd15;
	localparam logic [5:0] OP_TYA = 6'd16;
	localparam logic [5:0] OP_TYX = 6'd17;
	localparam logic [5:0] OP_TCD = 6'd18;
	localparam logic [5:0] OP_TCS = 6'd19;
	localparam logic [5:0] OP_TDC = 6'd20;
	localparam logic [5:0] OP_TSC = 6'd21;
	localparam logic [5:0] OP_TSX = 6'd22;
	localparam logic [5:0] OP_TXS = 6'd23;
	localparam logic [5:0] OP_PHA = 6'd24;
	localparam logic [5:0] OP_PHX = 6'd25;
	localparam logic [5:0] OP_PHY = 6'd26;
	localparam logic [5:0] OP_PHD = 6'd27;
	localparam logic [5:0] OP_PHB = 6'd28;
	localparam logic [5:0] OP_PHP = 6'd29;
	localparam logic [5:0] OP_PLA = 6'd30;
	localparam logic [5:0] OP_PLX = 6'd31;
	localparam logic [5:0] OP_PLY = 6'd32;
	localparam logic [5:0] OP_PLD = 6'd33;
	localparam logic [5:0] OP_PLB = 6'd34;
	localparam logic [5:0] OP_PLP = 6'd35;
	localparam logic [5:0] OP_PEA = 6'd36;
	localparam logic [5:0] OP_PEI = 6'd37;

	localparam logic [7:0] FLAG_N = 8'h80;
	localparam logic [7:0] FLAG_V = 8'h40;
	localparam logic [7:0] FLAG_M = 8'h20;
	localparam logic [7:0] FLAG_X = 8'h10;
	localparam logic [7:0] FLAG_D = 8'h08;
	localparam logic [7:0] FLAG_I = 8'h04;
	localparam logic [7:0] FLAG_Z = 8'h02;
	localparam logic [7:0] FLAG_C = 8'h01;
	localparam logic [7:0] FLAGS_ALL = 8'hFF;
	localparam logic [7:0] FLAGS_NONE = 8'h00;

	localparam logic [15:0] STACK_RST = 16'h01FF;
	localparam logic [7:0] STATUS_RST = 8'h34;
	localparam logic [7:0] STACK_PAGE_EMU = 8'h01;

	localparam logic [1:0] PC_NONE = 2'd0;
	localparam logic [1:0] PC_BYTE = 2'd1;
	localparam logic [1:0] PC_WORD = 2'd2;

	typedef enum logic [2:0] {
		K_NOP, K_XBA, K_XCE, K_FLAGS, K_LOAD, K_PUSH
	} kind_t;

	typedef enum logic [2:0] {
		S_A, S_X, S_Y, S_S, S_D, S_B, S_P, S_OPD
	} src_t;

	typedef enum logic [2:0] {
		D_A, D_A16, D_X, D_Y, D_D, D_S, D_B
	} dst_t;

	typedef enum logic [1:0] {
		PW_M, PW_X, PW_WORD, PW_BYTE
	} pw_t;

	typedef struct packed {
		logic [5:0] op;
		logic [15:0] operand;
	} req_t;

	typedef struct packed {
		logic [15:0] acc_out;
		logic [15:0] xidx_out;
		logic [15:0] yidx_out;
		logic [15:0] stack_out;
		logic [15:0] direct_out;
		logic [7:0] bank_out;
		logic [7:0] status_out;
		logic emu_out;
		logic [15:0] push_value;
		logic [1:0] push_count;
	} rsp_t;

	typedef struct packed {
		kind_t kind;
		src_t src;
		dst_t dst;
		pw_t pw;
		logic [7:0] clr;
		logic [7:0] set;
		logic [15:0] operand;
	} dec_t;

endpackage
`default_nettype wire

[hdl/crfu_front.sv]
// Front end: accepts instruction items, decodes them and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none
module crfu_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire crfu_pkg::req_t req,
	output logic dec_valid,
	input wire logic dec_full,
	output crfu_pkg::dec_t dec
);

	crfu_pkg::dec_t dec_c;
	crfu_pkg::dec_t dec_s1;
	logic valid_s1;
	logic push;
	logic load;

	always_comb begin
		dec_c = '{kind: crfu_pkg::K_NOP, src: crfu_pkg::S_A, dst: crfu_pkg::D_A,
			pw: crfu_pkg::PW_WORD, clr: crfu_pkg::FLAGS_NONE, set: crfu_pkg::FLAGS_NONE,
			operand: req.operand};
		case (req.op)
			crfu_pkg::OP_XBA: dec_c.kind = crfu_pkg::K_XBA;
			crfu_pkg::OP_XCE: dec_c.kind = crfu_pkg::K_XCE;
			crfu_pkg::OP_CLC: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.clr = crfu_pkg::FLAG_C; end
			crfu_pkg::OP_CLD: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.clr = crfu_pkg::FLAG_D; end
			crfu_pkg::OP_CLI: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.clr = crfu_pkg::FLAG_I; end
			crfu_pkg::OP_CLV: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.clr = crfu_pkg::FLAG_V; end
			crfu_pkg::OP_SEC: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.set = crfu_pkg::FLAG_C; end
			crfu_pkg::OP_SED: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.set = crfu_pkg::FLAG_D; end
			crfu_pkg::OP_SEI: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.set = crfu_pkg::FLAG_I; end
			crfu_pkg::OP_REP: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.clr = req.operand[7:0]; end
			crfu_pkg::OP_SEP: begin dec_c.kind = crfu_pkg::K_FLAGS; dec_c.set = req.operand[7:0]; end
			crfu_pkg::OP_PLP: begin
				dec_c.kind = crfu_pkg::K_FLAGS;
				dec_c.clr = crfu_pkg::FLAGS_ALL;
				dec_c.set = req.operand[7:0];
			end
			crfu_pkg::OP_TAX: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_A; dec_c.dst = crfu_pkg::D_X;
			end
			crfu_pkg::OP_TAY: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_A; dec_c.dst = crfu_pkg::D_Y;
			end
			crfu_pkg::OP_TXA: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_X; dec_c.dst = crfu_pkg::D_A;
			end
			crfu_pkg::OP_TXY: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_X; dec_c.dst = crfu_pkg::D_Y;
			end
			crfu_pkg::OP_TYA: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_Y; dec_c.dst = crfu_pkg::D_A;
			end
			crfu_pkg::OP_TYX: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_Y; dec_c.dst = crfu_pkg::D_X;
			end
			crfu_pkg::OP_TCD: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_A; dec_c.dst = crfu_pkg::D_D;
			end
			crfu_pkg::OP_TCS: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_A; dec_c.dst = crfu_pkg::D_S;
			end
			crfu_pkg::OP_TDC: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_D; dec_c.dst = crfu_pkg::D_A16;
			end
			crfu_pkg::OP_TSC: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_S; dec_c.dst = crfu_pkg::D_A16;
			end
			crfu_pkg::OP_TSX: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_S; dec_c.dst = crfu_pkg::D_X;
			end
			crfu_pkg::OP_TXS: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_X; dec_c.dst = crfu_pkg::D_S;
			end
			crfu_pkg::OP_PLA: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_OPD; dec_c.dst = crfu_pkg::D_A;
			end
			crfu_pkg::OP_PLX: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_OPD; dec_c.dst = crfu_pkg::D_X;
			end
			crfu_pkg::OP_PLY: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_OPD; dec_c.dst = crfu_pkg::D_Y;
			end
			crfu_pkg::OP_PLD: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_OPD; dec_c.dst = crfu_pkg::D_D;
			end
			crfu_pkg::OP_PLB: begin
				dec_c.kind = crfu_pkg::K_LOAD; dec_c.src = crfu_pkg::S_OPD; dec_c.dst = crfu_pkg::D_B;
			end
			crfu_pkg::OP_PHA: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_A; dec_c.pw = crfu_pkg::PW_M;
			end
			crfu_pkg::OP_PHX: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_X; dec_c.pw = crfu_pkg::PW_X;
			end
			crfu_pkg::OP_PHY: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_Y; dec_c.pw = crfu_pkg::PW_X;
			end
			crfu_pkg::OP_PHD: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_D; dec_c.pw = crfu_pkg::PW_WORD;
			end
			crfu_pkg::OP_PHB: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_B; dec_c.pw = crfu_pkg::PW_BYTE;
			end
			crfu_pkg::OP_PHP: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_P; dec_c.pw = crfu_pkg::PW_BYTE;
			end
			crfu_pkg::OP_PEA, crfu_pkg::OP_PEI: begin
				dec_c.kind = crfu_pkg::K_PUSH; dec_c.src = crfu_pkg::S_OPD;
				dec_c.pw = crfu_pkg::PW_WORD;
			end
			default: dec_c.kind = crfu_pkg::K_NOP;
		endcase
	end

	assign push = valid_s1 & ~dec_full;
	assign load = req_valid & ~req_stall;
	assign req_stall = valid_s1 & dec_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_s1 <= dec_c;
		end
	end

	assign dec_valid = valid_s1;
	assign dec = dec_s1;

endmodule
`default_nettype wire

[hdl/crfu_queue.sv]
// Short queue of decoded items between the front end and the execute stage.
`timescale 1ns / 1ps
`default_nettype none
module crfu_queue #(
	parameter int DEPTH = crfu_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic full,
	input wire crfu_pkg::dec_t wr_data,
	output logic rd_valid,
	input wire logic rd_pop,
	output crfu_pkg::dec_t rd_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	crfu_pkg::dec_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic wr;
	logic rd;

	assign full = count_q == CNT_W'(DEPTH);
	assign rd_valid = count_q != '0;
	assign wr = wr_valid & ~full;
	assign rd = rd_pop & rd_valid;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

[hdl/crfu_back.sv]
// Execute stage: register file, flag logic, mode fixups and the result register.
`timescale 1ns / 1ps
`default_nettype none
module crfu_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic dec_valid,
	output logic dec_pop,
	input wire crfu_pkg::dec_t dec,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output crfu_pkg::rsp_t rsp
);

	logic [15:0] a_q, x_q, y_q, s_q, d_q;
	logic [7:0] b_q, p_q;
	logic e_q;
	crfu_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	logic [15:0] a_n, x_n, y_n, s_n, d_n;
	logic [7:0] b_n, p_n, p_f;
	logic e_n;
	logic [15:0] x_f, y_f, s_f;
	logic [15:0] sv;
	logic [15:0] pv;
	logic [1:0] pc;
	logic nz_upd;
	logic nz_wide;
	logic [15:0] nz_val;
	logic m8, x8;

	assign m8 = p_q[5];
	assign x8 = p_q[4];
	assign dec_pop = dec_valid & (~rsp_valid_q | ~rsp_stall);

	always_comb begin
		case (dec.src)
			crfu_pkg::S_A: sv = a_q;
			crfu_pkg::S_X: sv = x_q;
			crfu_pkg::S_Y: sv = y_q;
			crfu_pkg::S_S: sv = s_q;
			crfu_pkg::S_D: sv = d_q;
			crfu_pkg::S_B: sv = {8'h00, b_q};
			crfu_pkg::S_P: sv = {8'h00, p_q};
			default: sv = dec.operand;
		endcase
	end

	always_comb begin
		a_n = a_q;
		x_n = x_q;
		y_n = y_q;
		s_n = s_q;
		d_n = d_q;
		b_n = b_q;
		p_n = p_q;
		e_n = e_q;
		pv = 16'h0000;
		pc = crfu_pkg::PC_NONE;
		nz_upd = 1'b0;
		nz_wide = 1'b0;
		nz_val = 16'h0000;
		case (dec.kind)
			crfu_pkg::K_XBA: begin
				a_n = {a_q[7:0], a_q[15:8]};
				nz_upd = 1'b1;
				nz_val = a_n;
			end
			crfu_pkg::K_XCE: begin
				p_n = {p_q[7:1], e_q};
				e_n = p_q[0];
			end
			crfu_pkg::K_FLAGS: p_n = (p_q & ~dec.clr) | dec.set;
			crfu_pkg::K_LOAD: begin
				nz_upd = 1'b1;
				case (dec.dst)
					crfu_pkg::D_A: begin
						a_n = m8 ? {a_q[15:8], sv[7:0]} : sv;
						nz_val = a_n;
						nz_wide = ~m8;
					end
					crfu_pkg::D_A16: begin
						a_n = sv;
						nz_val = sv;
						nz_wide = 1'b1;
					end
					crfu_pkg::D_X: begin
						x_n = x8 ? {x_q[15:8], sv[7:0]} : sv;
						nz_val = x_n;
						nz_wide = ~x8;
					end
					crfu_pkg::D_Y: begin
						y_n = x8 ? {y_q[15:8], sv[7:0]} : sv;
						nz_val = y_n;
						nz_wide = ~x8;
					end
					crfu_pkg::D_D: begin
						d_n = sv;
						nz_val = sv;
						nz_wide = 1'b1;
					end
					crfu_pkg::D_S: begin
						s_n = sv;
						nz_upd = 1'b0;
					end
					crfu_pkg::D_B: begin
						b_n = sv[7:0];
						nz_val = {8'h00, sv[7:0]};
					end
					default: nz_upd = 1'b0;
				endcase
			end
			crfu_pkg::K_PUSH: begin
				pv = sv;
				case (dec.pw)
					crfu_pkg::PW_M: pc = m8 ? crfu_pkg::PC_BYTE : crfu_pkg::PC_WORD;
					crfu_pkg::PW_X: pc = x8 ? crfu_pkg::PC_BYTE : crfu_pkg::PC_WORD;
					crfu_pkg::PW_WORD: pc = crfu_pkg::PC_WORD;
					default: pc = crfu_pkg::PC_BYTE;
				endcase
				if (pc == crfu_pkg::PC_BYTE) begin
					pv[15:8] = 8'h00;
				end
			end
			default: ;
		endcase
	end

	// N/Z update, then emulation and index width fixups
	always_comb begin
		p_f = p_n;
		if (nz_upd) begin
			p_f[7] = nz_wide ? nz_val[15] : nz_val[7];
			p_f[1] = nz_wide ? (nz_val == 16'h0000) : (nz_val[7:0] == 8'h00);
		end
		s_f = s_n;
		if (e_n) begin
			p_f = p_f | crfu_pkg::FLAG_M | crfu_pkg::FLAG_X;
			s_f = {crfu_pkg::STACK_PAGE_EMU, s_n[7:0]};
		end
		x_f = p_f[4] ? {8'h00, x_n[7:0]} : x_n;
		y_f = p_f[4] ? {8'h00, y_n[7:0]} : y_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			x_q <= '0;
			y_q <= '0;
			s_q <= crfu_pkg::STACK_RST;
			d_q <= '0;
			b_q <= '0;
			p_q <= crfu_pkg::STATUS_RST;
			e_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dec_pop) begin
				a_q <= a_n;
				x_q <= x_f;
				y_q <= y_f;
				s_q <= s_f;
				d_q <= d_n;
				b_q <= b_n;
				p_q <= p_f;
				e_q <= e_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_pop) begin
			rsp_q <= '{acc_out: a_n, xidx_out: x_f, yidx_out: y_f, stack_out: s_f,
				direct_out: d_n, bank_out: b_n, status_out: p_f, emu_out: e_n,
				push_value: pv, push_count: pc};
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

endmodule
`default_nettype wire

[hdl/cpu16_register_flag_unit.sv]
// An item passes the decode register, the queue and the result register to rsp.
// Throughput: one item per cycle while rsp_stall is low; execute retires one per cycle.
// The QUEUE_DEPTH queue lets the front end keep accepting while rsp stalls, until full.
// Reset (arst_n low, asynchronous): A, X, Y, D, DB = 0, S = 0x01FF, P = 0x34, E = 1,
// queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
module cpu16_register_flag_unit #(
	parameter int QUEUE_DEPTH = crfu_pkg::QUEUE_DEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire crfu_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output crfu_pkg::rsp_t rsp
);

	logic fq_valid;
	logic fq_full;
	crfu_pkg::dec_t fq_data;
	logic qb_valid;
	logic qb_pop;
	crfu_pkg::dec_t qb_data;

	crfu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.dec_valid(fq_valid),
		.dec_full(fq_full),
		.dec(fq_data)
	);

	crfu_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(fq_valid),
		.full(fq_full),
		.wr_data(fq_data),
		.rd_valid(qb_valid),
		.rd_pop(qb_pop),
		.rd_data(qb_data)
	);

	crfu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.dec_valid(qb_valid),
		.dec_pop(qb_pop),
		.dec(qb_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

[hdl/crfu_checker.sv]
// Port-level checker for the register and flag unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module crfu_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire crfu_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result dropped or changed");

	a_emu_modes: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.emu_out |-> rsp.status_out[5] && rsp.status_out[4])
		else $error("emulation mode without M and X set");

	a_emu_stack: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.emu_out |-> rsp.stack_out[15:8] == crfu_pkg::STACK_PAGE_EMU)
		else $error("emulation mode stack outside page one");

	a_index_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status_out[4] |-> rsp.xidx_out[15:8] == 8'h00
			&& rsp.yidx_out[15:8] == 8'h00)
		else $error("8-bit index with nonzero high byte");

	a_push_byte: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.push_count != crfu_pkg::PC_WORD |-> rsp.push_value[15:8] == 8'h00)
		else $error("byte push with high bits set");

endmodule

bind cpu16_register_flag_unit crfu_checker u_crfu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);
`default_nettype wire
